// ----- rtl/gcl_pkg.sv -----
package gcl_pkg;

  localparam int OPERAND_BITS_DEF = 16;
  localparam int FIELD_BITS       = 16;
  localparam int RESULT_BITS      = 32;

  localparam logic OP_GCD = 1'b0;
  localparam logic OP_LCM = 1'b1;

  typedef struct packed {
    logic load;
    logic gcd_step;
    logic div_start;
    logic div_step;
    logic mul;
    logic publish;
  } gcl_cmd_t;

  typedef struct packed {
    logic in_zero;
    logic gcd_done;
    logic div_last;
    logic is_lcm;
  } gcl_status_t;

endpackage

// ----- rtl/gcl_datapath.sv -----
module gcl_datapath
  import gcl_pkg::*;
#(
  parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
  input  logic                   clk,
  input  logic [FIELD_BITS-1:0]  in_a,
  input  logic [FIELD_BITS-1:0]  in_b,
  input  logic                   in_op,
  input  gcl_cmd_t               cmd,
  output gcl_status_t            status,
  output logic [RESULT_BITS-1:0] result,
  output logic                   zero_err
);

  localparam int W  = (OPERAND_BITS < FIELD_BITS) ? OPERAND_BITS : FIELD_BITS;
  localparam int KW = $clog2(W);

  logic [W-1:0]   a_op;
  logic [W-1:0]   b_op;
  logic [W-1:0]   x;
  logic [W-1:0]   y;
  logic [KW-1:0]  k;
  logic           op;
  logic           zero;
  logic [W-1:0]   divisor;
  logic [W-1:0]   rem;
  logic [W-1:0]   quo;
  logic [KW-1:0]  div_cnt;
  logic [2*W-1:0] prod;
  logic [W-1:0]   b_keep;

  logic [W-1:0]   g_full;
  logic [W:0]     r_sh;
  logic [W:0]     r_diff;
  logic [W-1:0]   x_m_y;
  logic [W-1:0]   y_m_x;

  assign a_op   = in_a[W-1:0];
  assign b_op   = in_b[W-1:0];
  assign g_full = x << k;
  assign r_sh   = {rem, quo[W-1]};
  assign r_diff = r_sh - {1'b0, divisor};
  assign x_m_y  = x - y;
  assign y_m_x  = y - x;

  assign status.in_zero  = (a_op == '0) || (b_op == '0);
  assign status.gcd_done = (x == y);
  assign status.div_last = (div_cnt == '0);
  assign status.is_lcm   = (op == OP_LCM);

  // Binary GCD: common factors of two are counted in k, odd parts are
  // reduced by halved differences until both values meet.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x    <= a_op;
      y    <= b_op;
      k    <= '0;
      op   <= in_op;
      zero <= status.in_zero;
      quo  <= a_op;
    end else if (cmd.gcd_step) begin
      if (!x[0] && !y[0]) begin
        x <= x >> 1;
        y <= y >> 1;
        k <= k + 1'b1;
      end else if (!x[0]) begin
        x <= x >> 1;
      end else if (!y[0]) begin
        y <= y >> 1;
      end else if (x > y) begin
        x <= x_m_y >> 1;
      end else begin
        y <= y_m_x >> 1;
      end
    end

    // Restoring division of operand a by the GCD, one quotient bit a beat.
    if (cmd.div_start) begin
      divisor <= g_full;
      rem     <= '0;
      div_cnt <= KW'(W - 1);
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt - 1'b1;
      if (!r_diff[W]) begin
        rem <= r_diff[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= r_sh[W-1:0];
        quo <= {quo[W-2:0], 1'b0};
      end
    end

    if (cmd.mul) begin
      prod <= quo * b_keep;
    end

    if (cmd.publish) begin
      zero_err <= zero;
      if (zero) begin
        result <= '0;
      end else if (op == OP_LCM) begin
        result <= RESULT_BITS'(prod);
      end else begin
        result <= RESULT_BITS'(g_full);
      end
    end
  end

  // Operand b is kept for the multiply; x and y are consumed by the GCD.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      b_keep <= b_op;
    end
  end

endmodule

// ----- rtl/gcl_ctrl.sv -----
module gcl_ctrl
  import gcl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  gcl_status_t status,
  output gcl_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_GCD  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = status.in_zero ? ST_DONE : ST_GCD;
        end
      end
      ST_GCD: begin
        if (!status.gcd_done) begin
          cmd.gcd_step = 1'b1;
        end else if (status.is_lcm) begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.publish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.publish) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- rtl/gcd_lcm_unit.sv -----
// Channel  Direction  tdata                                  tuser
// s_axis   in         [15:0] operand_a, [31:16] operand_b    [0] opcode
// m_axis   out        [31:0] result_value                    [0] zero_error
//
// An item is accepted, runs the binary GCD loop until both values meet, and
// is then published; LCM first adds a division of operand a by the GCD and a
// multiply by operand b. An item with a zero operand goes straight from accept
// to publishing.
// One item is in work at a time; the result register lets the next item be
// accepted while the previous result waits on m_axis_tready.
// Reset (rst, synchronous) returns the controller to idle and drops tvalid.
module gcd_lcm_unit
  import gcl_pkg::*;
#(
  parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // operand_a, operand_b
  input  logic        s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // result_value
  output logic        m_axis_tuser    // zero_error
);

  gcl_cmd_t    cmd;
  gcl_status_t status;

  gcl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  gcl_datapath #(
    .OPERAND_BITS (OPERAND_BITS)
  ) u_datapath (
    .clk      (clk),
    .in_a     (s_axis_tdata[15:0]),
    .in_b     (s_axis_tdata[31:16]),
    .in_op    (s_axis_tuser),
    .cmd      (cmd),
    .status   (status),
    .result   (m_axis_tdata),
    .zero_err (m_axis_tuser)
  );

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import gcl_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int DRAIN_CYCLES  = 200;
  localparam int LONG_STALL    = 400;
  localparam int RANDOM_ITEMS  = 1360;

  typedef struct packed {
    logic [31:0] value;
    logic        zero_error;
  } gcd_lcm_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // operand_a, operand_b
  logic        s_axis_tuser = 1'b0; // opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // result_value
  logic        m_axis_tuser;        // zero_error

  gcd_lcm_result_t pending_results[$];
  int              mismatches = 0;
  int              cycles = 0;
  int              burst_left = 0;
  int              stall_requests = 0;
  int              stall_served = 0;

  gcd_lcm_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("gcd_lcm_unit regression: fail");
      $finish;
    end
  end

  function automatic gcd_lcm_result_t gcd_lcm_predict(logic [15:0] a, logic [15:0] b,
                                                      logic op);
    longint unsigned x;
    longint unsigned y;
    longint unsigned r;
    longint unsigned value;
    gcd_lcm_result_t res;
    if (a == 16'd0 || b == 16'd0) begin
      res.value      = 32'd0;
      res.zero_error = 1'b1;
      return res;
    end
    x = a;
    y = b;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    if (op == OP_GCD) begin
      value = x;
    end else begin
      value = (longint'(a) / x) * longint'(b);
      if (value > 64'hFFFF_FFFF) value = 64'hFFFF_FFFF;
    end
    res.value      = value[31:0];
    res.zero_error = 1'b0;
    return res;
  endfunction

  // Sender: bursts of random length separated by idle gaps. tvalid stays high
  // from one beat to the next inside a burst.
  task automatic send_operands(input logic [15:0] a, input logic [15:0] b, input logic op);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, a};
    s_axis_tuser  <= op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_results.push_back(gcd_lcm_predict(a, b, op));
    burst_left--;
  endtask

  // Receiver: runs of different stall behavior, plus an occasional long stall
  // requested by a test.
  always @(posedge clk) begin
    int run_left;
    int ready_pct;
    int stall_left;
    if (rst) begin
      m_axis_tready <= 1'b0;
      run_left   = 0;
      ready_pct  = 100;
      stall_left = 0;
    end else begin
      if (stall_requests != stall_served) begin
        stall_served++;
        stall_left = LONG_STALL;
      end
      if (run_left == 0) begin
        run_left = $urandom_range(20, 200);
        case ($urandom_range(0, 3))
          0: ready_pct = 100;
          1: ready_pct = 75;
          2: ready_pct = 40;
          default: ready_pct = 10;
        endcase
      end
      run_left--;
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(1, 100) <= ready_pct);
      end
    end
  end

  always @(posedge clk) begin
    gcd_lcm_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: result_value %0d zero_error %0d",
               m_axis_tdata, m_axis_tuser);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata !== want.value) begin
          $error("result_value: expected %0d, actual %0d", want.value, m_axis_tdata);
          mismatches++;
        end
        if (m_axis_tuser !== want.zero_error) begin
          $error("zero_error: expected %0d, actual %0d", want.zero_error, m_axis_tuser);
          mismatches++;
        end
      end
    end
  end

  task automatic test_zero_operands();
    send_operands(16'd0, 16'd0, OP_GCD);
    send_operands(16'd0, 16'd5, OP_LCM);
    send_operands(16'd7, 16'd0, OP_GCD);
    send_operands(16'd0, 16'hFFFF, OP_LCM);
    send_operands(16'hFFFF, 16'd0, OP_LCM);
    send_operands(16'd0, 16'd1, OP_GCD);
  endtask

  task automatic test_extremes();
    send_operands(16'hFFFF, 16'hFFFF, OP_GCD);
    send_operands(16'hFFFF, 16'hFFFF, OP_LCM);
    send_operands(16'd1, 16'd1, OP_GCD);
    send_operands(16'd1, 16'd1, OP_LCM);
    send_operands(16'd1, 16'hFFFF, OP_LCM);
    send_operands(16'hFFFF, 16'd1, OP_GCD);
    send_operands(16'hFFFE, 16'hFFFF, OP_LCM);
    // Two large primes give an LCM equal to their full product.
    send_operands(16'd65521, 16'd65519, OP_LCM);
    send_operands(16'd65521, 16'd65519, OP_GCD);
    send_operands(16'h8000, 16'h4000, OP_GCD);
    send_operands(16'h8000, 16'h4000, OP_LCM);
  endtask

  task automatic test_gcd_lcm_basic();
    send_operands(16'd12, 16'd18, OP_GCD);
    send_operands(16'd12, 16'd18, OP_LCM);
    send_operands(16'd48, 16'd180, OP_GCD);
    send_operands(16'd17, 16'd19, OP_LCM);
    send_operands(16'd2, 16'd2, OP_LCM);
    send_operands(16'd46368, 16'd28657, OP_GCD);
  endtask

  task automatic send_random_item();
    logic [15:0] a;
    logic [15:0] b;
    int          f;
    int          kind;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      a = 16'($urandom);
      b = 16'($urandom);
    end else if (kind < 65) begin
      // Shared factor so the divisor is usually well above one.
      f = $urandom_range(1, 255);
      a = 16'(f * $urandom_range(1, 65535 / f));
      b = 16'(f * $urandom_range(1, 65535 / f));
    end else if (kind < 85) begin
      a = 16'($urandom_range(0, 31));
      b = 16'($urandom_range(0, 31));
    end else if (kind < 95) begin
      a = 16'd1 << $urandom_range(0, 15);
      b = $urandom_range(0, 1) ? (16'd1 << $urandom_range(0, 15)) : 16'($urandom);
    end else begin
      a = $urandom_range(0, 1) ? 16'd0 : 16'($urandom);
      b = (a == 16'd0) ? 16'($urandom) : 16'd0;
    end
    send_operands(a, b, 1'($urandom_range(0, 1)));
  endtask

  task automatic test_random_mix(input int count);
    repeat (count) send_random_item();
  endtask

  // The receiver holds off while the sender keeps offering beats, so the
  // block fills up and has to drop s_axis_tready.
  task automatic test_backpressure();
    stall_requests++;
    burst_left = 40;
    repeat (12) send_random_item();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_zero_operands();
    test_extremes();
    test_gcd_lcm_basic();
    test_random_mix(RANDOM_ITEMS / 2);
    test_backpressure();
    test_random_mix(RANDOM_ITEMS / 2);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("gcd_lcm_unit regression: pass");
    end else begin
      $display("gcd_lcm_unit regression: fail");
    end
    $finish;
  end

endmodule

// ----- gcd_lcm_unit.f -----
rtl/gcl_pkg.sv
rtl/gcl_datapath.sv
rtl/gcl_ctrl.sv
rtl/gcd_lcm_unit.sv
dv/tb.sv
